>>> design/tdcls_pkg.sv
// ----------------------------------------------------------------------------
// Tick-driven clock and LED scanner package
// Shared widths, reset values, codes, types and small decode functions.
// ----------------------------------------------------------------------------
package tdcls_pkg;

    localparam int unsigned PERIOD_W        = 10;
    localparam int unsigned GLYPH_W         = 32;
    localparam int unsigned CFG_DATA_W      = 32;
    localparam int unsigned CFG_IDX_W       = 3;
    localparam int unsigned NUM_JOBS        = 5;
    localparam int unsigned DIGITS_DEF      = 4;
    localparam int unsigned MATRIX_ROWS_DEF = 8;
    localparam int unsigned SHOWN_DIGITS    = 4;
    localparam int unsigned ENABLE_W        = 4;
    localparam int unsigned SEG_W           = 7;
    localparam int unsigned ROW_W           = 8;
    localparam int unsigned COL_W           = 8;
    localparam int unsigned HOUR_W          = 5;
    localparam int unsigned MIN_W           = 6;
    localparam int unsigned SEC_W           = 6;
    localparam int unsigned SCROLL_W        = 4;
    localparam int unsigned ROW_SEL_W       = 3;
    localparam int unsigned SCROLL_PERIOD   = 9;
    localparam int unsigned GLYPH_COLS      = 8;

    // Job indexes into the period and countdown arrays.
    localparam int unsigned JOB_SCAN   = 0;
    localparam int unsigned JOB_DOT    = 1;
    localparam int unsigned JOB_RED    = 2;
    localparam int unsigned JOB_SECOND = 3;
    localparam int unsigned JOB_ROW    = 4;

    localparam logic [NUM_JOBS-1:0][PERIOD_W-1:0] PERIOD_RST =
        {10'd10, 10'd100, 10'd50, 10'd75, 10'd25};
    localparam logic [GLYPH_W-1:0] GLYPH_LOW_RST  = 32'h4242_2418;
    localparam logic [GLYPH_W-1:0] GLYPH_HIGH_RST = 32'h4242_427E;

    localparam logic [HOUR_W-1:0] HOUR_RST = 5'd15;
    localparam logic [MIN_W-1:0]  MIN_RST  = 6'd8;
    localparam logic [SEC_W-1:0]  SEC_RST  = 6'd50;

    localparam int unsigned SECONDS_PER_MINUTE = 60;
    localparam int unsigned MINUTES_PER_HOUR   = 60;
    localparam int unsigned HOURS_PER_DAY      = 24;

    localparam logic [SEG_W-1:0] SEG_G_ONLY = 7'h40;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIGIT_SCAN  = 3'd0,
        CFG_DOT_BLINK   = 3'd1,
        CFG_RED_BLINK   = 3'd2,
        CFG_SECOND      = 3'd3,
        CFG_ROW_SCAN    = 3'd4,
        CFG_GLYPH_LOW   = 3'd5,
        CFG_GLYPH_HIGH  = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIG_HOUR_TENS  = 2'd0,
        DIG_HOUR_UNITS = 2'd1,
        DIG_MIN_TENS   = 2'd2,
        DIG_MIN_UNITS  = 2'd3
    } t_digit_pos;

    typedef struct packed {
        logic [NUM_JOBS-1:0][PERIOD_W-1:0] period;
        logic [GLYPH_W-1:0]                glyph_low;
        logic [GLYPH_W-1:0]                glyph_high;
    } t_cfg;

    // Scan job sits in bit 0, matching the job indexes above.
    typedef struct packed {
        logic row;
        logic second;
        logic red;
        logic dot;
        logic scan;
    } t_fire;

    typedef struct packed {
        logic [ENABLE_W-1:0] digit_enable_n;
        logic [SEG_W-1:0]    segments_n;
        logic                dot_led;
        logic                red_led;
        logic [ROW_W-1:0]    matrix_rows;
        logic [COL_W-1:0]    matrix_columns;
        logic [HOUR_W-1:0]   clock_hours;
        logic [MIN_W-1:0]    clock_minutes;
        logic [SEC_W-1:0]    clock_seconds;
    } t_result;

    // Tens digit of a value below 64, by a short compare chain.
    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] t;
        if (v >= 6'd60) begin
            t = 3'd6;
        end else if (v >= 6'd50) begin
            t = 3'd5;
        end else if (v >= 6'd40) begin
            t = 3'd4;
        end else if (v >= 6'd30) begin
            t = 3'd3;
        end else if (v >= 6'd20) begin
            t = 3'd2;
        end else if (v >= 6'd10) begin
            t = 3'd1;
        end else begin
            t = 3'd0;
        end
        return t;
    endfunction

    function automatic logic [3:0] units_of(input logic [5:0] v);
        logic [5:0] t10;
        t10 = 6'(tens_of(v)) * 6'd10;
        return 4'(v - t10);
    endfunction

    // Active-high segments a..g in bits 0..6; anything above 9 lights g only.
    function automatic logic [SEG_W-1:0] seg_decode(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = SEG_G_ONLY;
        endcase
        return s;
    endfunction

endpackage

>>> design/tdcls_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Five period registers and two glyph words, written through a plain port.
// ----------------------------------------------------------------------------
module tdcls_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tdcls_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tdcls_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output tdcls_pkg::t_cfg                     o_cfg
);

    tdcls_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period     <= tdcls_pkg::PERIOD_RST;
            r_cfg.glyph_low  <= tdcls_pkg::GLYPH_LOW_RST;
            r_cfg.glyph_high <= tdcls_pkg::GLYPH_HIGH_RST;
        end else if (i_cfg_we) begin
            case (tdcls_pkg::t_cfg_idx'(i_cfg_index))
                tdcls_pkg::CFG_DIGIT_SCAN: begin
                    r_cfg.period[tdcls_pkg::JOB_SCAN] <=
                        i_cfg_data[tdcls_pkg::PERIOD_W-1:0];
                end
                tdcls_pkg::CFG_DOT_BLINK: begin
                    r_cfg.period[tdcls_pkg::JOB_DOT] <=
                        i_cfg_data[tdcls_pkg::PERIOD_W-1:0];
                end
                tdcls_pkg::CFG_RED_BLINK: begin
                    r_cfg.period[tdcls_pkg::JOB_RED] <=
                        i_cfg_data[tdcls_pkg::PERIOD_W-1:0];
                end
                tdcls_pkg::CFG_SECOND: begin
                    r_cfg.period[tdcls_pkg::JOB_SECOND] <=
                        i_cfg_data[tdcls_pkg::PERIOD_W-1:0];
                end
                tdcls_pkg::CFG_ROW_SCAN: begin
                    r_cfg.period[tdcls_pkg::JOB_ROW] <=
                        i_cfg_data[tdcls_pkg::PERIOD_W-1:0];
                end
                tdcls_pkg::CFG_GLYPH_LOW: begin
                    r_cfg.glyph_low <= i_cfg_data[tdcls_pkg::GLYPH_W-1:0];
                end
                tdcls_pkg::CFG_GLYPH_HIGH: begin
                    r_cfg.glyph_high <= i_cfg_data[tdcls_pkg::GLYPH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/tdcls_job_timers.sv
// ----------------------------------------------------------------------------
// Job countdowns
// Five tick countdowns that reload from their period and flag an expiry.
// ----------------------------------------------------------------------------
module tdcls_job_timers (
    input  logic                                                      i_clk,
    input  logic                                                      i_rst_n,
    input  logic                                                      i_step,
    input  logic [tdcls_pkg::NUM_JOBS-1:0][tdcls_pkg::PERIOD_W-1:0]  i_period,
    output tdcls_pkg::t_fire                                          o_fire
);

    logic [tdcls_pkg::NUM_JOBS-1:0][tdcls_pkg::PERIOD_W-1:0] r_count;
    logic [tdcls_pkg::NUM_JOBS-1:0][tdcls_pkg::PERIOD_W-1:0] n_count;
    logic [tdcls_pkg::NUM_JOBS-1:0]                          w_expire;

    // A countdown holding one or zero expires on this tick and reloads.
    always_comb begin
        for (int j = 0; j < tdcls_pkg::NUM_JOBS; j++) begin
            w_expire[j] = (r_count[j] <= tdcls_pkg::PERIOD_W'(1));
            if (w_expire[j]) begin
                n_count[j] = i_period[j];
            end else begin
                n_count[j] = r_count[j] - tdcls_pkg::PERIOD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= tdcls_pkg::PERIOD_RST;
        end else if (i_step) begin
            r_count <= n_count;
        end
    end

    assign o_fire = tdcls_pkg::t_fire'(w_expire & {tdcls_pkg::NUM_JOBS{i_step}});

endmodule

>>> design/tdcls_scan_core.sv
// ----------------------------------------------------------------------------
// Clock and scanner state
// Time of day, digit and row scanning, blink levels and the output latches.
// ----------------------------------------------------------------------------
module tdcls_scan_core #(
    parameter int unsigned DIGITS      = tdcls_pkg::DIGITS_DEF,
    parameter int unsigned MATRIX_ROWS = tdcls_pkg::MATRIX_ROWS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  tdcls_pkg::t_fire                i_fire,
    input  logic [tdcls_pkg::GLYPH_W-1:0]   i_glyph_low,
    input  logic [tdcls_pkg::GLYPH_W-1:0]   i_glyph_high,
    output tdcls_pkg::t_result              o_result
);

    localparam int unsigned DSEL_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    logic [DSEL_W-1:0]                  r_digit_sel,  n_digit_sel;
    logic [tdcls_pkg::ROW_SEL_W-1:0]    r_row_sel,    n_row_sel;
    logic [tdcls_pkg::SCROLL_W-1:0]     r_scroll,     n_scroll;
    logic [tdcls_pkg::HOUR_W-1:0]       r_hours,      n_hours;
    logic [tdcls_pkg::MIN_W-1:0]        r_minutes,    n_minutes;
    logic [tdcls_pkg::SEC_W-1:0]        r_seconds,    n_seconds;
    logic                               r_dot,        n_dot;
    logic                               r_red,        n_red;
    logic [tdcls_pkg::ENABLE_W-1:0]     r_enable_n,   n_enable_n;
    logic [tdcls_pkg::SEG_W-1:0]        r_segments_n, n_segments_n;
    logic [tdcls_pkg::ROW_W-1:0]        r_rows,       n_rows;
    logic [tdcls_pkg::COL_W-1:0]        r_columns,    n_columns;

    logic [3:0]                         w_dsel_ext;
    logic [3:0]                         w_digit_val;
    logic [tdcls_pkg::GLYPH_W-1:0]      w_glyph_word;
    logic [7:0]                         w_row_bits;
    logic [3:0]                         w_row_inc;
    logic [tdcls_pkg::COL_W-1:0]        w_cols;

    // Seven-segment digit scan, using the time before this tick's second.
    always_comb begin
        w_dsel_ext = 4'(r_digit_sel);
        case (tdcls_pkg::t_digit_pos'(w_dsel_ext[1:0]))
            tdcls_pkg::DIG_HOUR_TENS:  w_digit_val = 4'(tdcls_pkg::tens_of(6'(r_hours)));
            tdcls_pkg::DIG_HOUR_UNITS: w_digit_val = tdcls_pkg::units_of(6'(r_hours));
            tdcls_pkg::DIG_MIN_TENS:   w_digit_val = 4'(tdcls_pkg::tens_of(r_minutes));
            tdcls_pkg::DIG_MIN_UNITS:  w_digit_val = tdcls_pkg::units_of(r_minutes);
            default:                   w_digit_val = 4'd0;
        endcase

        n_enable_n   = r_enable_n;
        n_segments_n = r_segments_n;
        n_digit_sel  = r_digit_sel;
        if (i_fire.scan) begin
            if (w_dsel_ext < 4'(tdcls_pkg::SHOWN_DIGITS)) begin
                n_enable_n   = ~(4'b0001 << w_dsel_ext[1:0]);
                n_segments_n = ~tdcls_pkg::seg_decode(w_digit_val);
            end else begin
                n_enable_n = '1;
            end
            if (r_digit_sel == DSEL_W'(DIGITS - 1)) begin
                n_digit_sel = '0;
            end else begin
                n_digit_sel = r_digit_sel + DSEL_W'(1);
            end
        end
    end

    // Blink levels.
    always_comb begin
        n_dot = r_dot ^ i_fire.dot;
        n_red = r_red ^ i_fire.red;
    end

    // Time of day with the usual rollover.
    always_comb begin
        n_seconds = r_seconds;
        n_minutes = r_minutes;
        n_hours   = r_hours;
        if (i_fire.second) begin
            if (r_seconds >= tdcls_pkg::SEC_W'(tdcls_pkg::SECONDS_PER_MINUTE - 1)) begin
                n_seconds = '0;
                if (r_minutes >= tdcls_pkg::MIN_W'(tdcls_pkg::MINUTES_PER_HOUR - 1)) begin
                    n_minutes = '0;
                    if (r_hours >= tdcls_pkg::HOUR_W'(tdcls_pkg::HOURS_PER_DAY - 1)) begin
                        n_hours = '0;
                    end else begin
                        n_hours = r_hours + tdcls_pkg::HOUR_W'(1);
                    end
                end else begin
                    n_minutes = r_minutes + tdcls_pkg::MIN_W'(1);
                end
            end else begin
                n_seconds = r_seconds + tdcls_pkg::SEC_W'(1);
            end
        end
    end

    // Matrix row: column c shows glyph column (c + offset) mod 9, column 8 blank.
    always_comb begin
        logic [4:0] g;
        w_glyph_word = r_row_sel[2] ? i_glyph_high : i_glyph_low;
        w_row_bits   = 8'(w_glyph_word >> {r_row_sel[1:0], 3'b000});
        for (int c = 0; c < tdcls_pkg::COL_W; c++) begin
            g = 5'(c) + 5'(r_scroll);
            if (g >= 5'(tdcls_pkg::SCROLL_PERIOD)) begin
                g = g - 5'(tdcls_pkg::SCROLL_PERIOD);
            end
            w_cols[c] = (g < 5'(tdcls_pkg::GLYPH_COLS)) && w_row_bits[3'(5'd7 - g)];
        end

        w_row_inc = 4'(r_row_sel) + 4'd1;
        n_rows    = r_rows;
        n_columns = r_columns;
        n_row_sel = r_row_sel;
        n_scroll  = r_scroll;
        if (i_fire.row) begin
            n_rows    = 8'b0000_0001 << r_row_sel;
            n_columns = w_cols;
            if (w_row_inc >= 4'(MATRIX_ROWS)) begin
                n_row_sel = '0;
                if (r_scroll == tdcls_pkg::SCROLL_W'(tdcls_pkg::SCROLL_PERIOD - 1)) begin
                    n_scroll = '0;
                end else begin
                    n_scroll = r_scroll + tdcls_pkg::SCROLL_W'(1);
                end
            end else begin
                n_row_sel = w_row_inc[2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_sel  <= '0;
            r_row_sel    <= '0;
            r_scroll     <= '0;
            r_hours      <= tdcls_pkg::HOUR_RST;
            r_minutes    <= tdcls_pkg::MIN_RST;
            r_seconds    <= tdcls_pkg::SEC_RST;
            r_dot        <= 1'b0;
            r_red        <= 1'b0;
            r_enable_n   <= '0;
            r_segments_n <= '0;
            r_rows       <= '0;
            r_columns    <= '0;
        end else if (i_step) begin
            r_digit_sel  <= n_digit_sel;
            r_row_sel    <= n_row_sel;
            r_scroll     <= n_scroll;
            r_hours      <= n_hours;
            r_minutes    <= n_minutes;
            r_seconds    <= n_seconds;
            r_dot        <= n_dot;
            r_red        <= n_red;
            r_enable_n   <= n_enable_n;
            r_segments_n <= n_segments_n;
            r_rows       <= n_rows;
            r_columns    <= n_columns;
        end
    end

    always_comb begin
        o_result.digit_enable_n = r_enable_n;
        o_result.segments_n     = r_segments_n;
        o_result.dot_led        = r_dot;
        o_result.red_led        = r_red;
        o_result.matrix_rows    = r_rows;
        o_result.matrix_columns = r_columns;
        o_result.clock_hours    = r_hours;
        o_result.clock_minutes  = r_minutes;
        o_result.clock_seconds  = r_seconds;
    end

endmodule

>>> design/tick_driven_clock_and_led_scanner_top.sv
// ----------------------------------------------------------------------------
// Tick-driven clock and LED scanner, top level
// Counts base ticks into five jobs: digit scan, dot blink, red blink, clock
// second and LED matrix row scan, and reports all display outputs per request.
// ----------------------------------------------------------------------------
// Usage:
// Each input request carries one bit, i_tick. A request with i_tick high
// advances every job countdown by one tick; a countdown that holds one or
// zero fires its job and reloads from its period register. A request with
// i_tick low changes nothing. Every input request produces exactly one
// output request holding the display and clock values after that update.
// The result of a request accepted at one edge is valid on the output
// from the next cycle on. Throughput is one request per cycle while the
// receiver does not stall, set by the single state update between the input
// handshake and the state registers, which double as the output register.
// When the receiver stalls, the output holds its payload and o_in_ready drops
// until the pending result is taken; o_in_ready follows i_out_ready in the
// same cycle, so a result and a new request can be exchanged every cycle.
// Synchronous active-low reset loads the clock to 15:08:50, the periods and
// glyph words to their defaults, reloads the countdowns from those defaults
// and clears the scan positions, blink levels and output latches.
// Configuration writes take effect in the cycle after i_cfg_we; a new period
// is picked up at that job's next reload.
// ----------------------------------------------------------------------------
module tick_driven_clock_and_led_scanner_top #(
    parameter int unsigned DIGITS      = tdcls_pkg::DIGITS_DEF,
    parameter int unsigned MATRIX_ROWS = tdcls_pkg::MATRIX_ROWS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [tdcls_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tdcls_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Input channel.
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_tick,
    // Output channel.
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [tdcls_pkg::ENABLE_W-1:0]      o_digit_enable_n,
    output logic [tdcls_pkg::SEG_W-1:0]         o_segments_n,
    output logic                                o_dot_led,
    output logic                                o_red_led,
    output logic [tdcls_pkg::ROW_W-1:0]         o_matrix_rows,
    output logic [tdcls_pkg::COL_W-1:0]         o_matrix_columns,
    output logic [tdcls_pkg::HOUR_W-1:0]        o_clock_hours,
    output logic [tdcls_pkg::MIN_W-1:0]         o_clock_minutes,
    output logic [tdcls_pkg::SEC_W-1:0]         o_clock_seconds
);

    tdcls_pkg::t_cfg    w_cfg;
    tdcls_pkg::t_fire   w_fire;
    tdcls_pkg::t_result w_result;

    logic r_out_valid;
    logic n_out_valid;
    logic w_accept;
    logic w_step;

    // The state only moves on an accepted request, and a request is only
    // accepted when the output slot is empty or being emptied, so the
    // payload stays stable while the receiver stalls.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_step     = w_accept && i_tick;

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    tdcls_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    tdcls_job_timers u_job_timers (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_period (w_cfg.period),
        .o_fire   (w_fire)
    );

    tdcls_scan_core #(
        .DIGITS      (DIGITS),
        .MATRIX_ROWS (MATRIX_ROWS)
    ) u_scan_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_fire       (w_fire),
        .i_glyph_low  (w_cfg.glyph_low),
        .i_glyph_high (w_cfg.glyph_high),
        .o_result     (w_result)
    );

    assign o_out_valid      = r_out_valid;
    assign o_digit_enable_n = w_result.digit_enable_n;
    assign o_segments_n     = w_result.segments_n;
    assign o_dot_led        = w_result.dot_led;
    assign o_red_led        = w_result.red_led;
    assign o_matrix_rows    = w_result.matrix_rows;
    assign o_matrix_columns = w_result.matrix_columns;
    assign o_clock_hours    = w_result.clock_hours;
    assign o_clock_minutes  = w_result.clock_minutes;
    assign o_clock_seconds  = w_result.clock_seconds;

`ifndef SYNTHESIS
    // Every accepted request leaves a result waiting in the next cycle.
    a_result_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out_valid)
        else $error("accepted request produced no result");

    // At most one matrix row is driven at a time.
    a_rows_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_matrix_rows))
        else $error("more than one matrix row driven");

    // At most one digit enable is active, apart from the cleared enable
    // latch that reset leaves until the first digit scan.
    a_one_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_digit_enable_n == '0) || $onehot0(~o_digit_enable_n))
        else $error("more than one digit enabled");

    // The clock stays a valid time of day.
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_clock_hours < 5'd24) && (o_clock_minutes < 6'd60) &&
        (o_clock_seconds < 6'd60))
        else $error("clock out of range");

    // No state change without an accepted tick.
    a_hold_without_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_step |=> $stable(o_clock_seconds) && $stable(o_matrix_columns))
        else $error("state changed without a tick");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the tick-driven clock and LED scanner
// Drives tick requests and register writes into the scanner, predicts every
// display result with an independent model of the five job countdowns, the
// digit and row scans and the 24-hour clock, and checks each result field.
// ----------------------------------------------------------------------------
module testbench;

    import tdcls_pkg::*;

    // The block's result for each request is valid from the cycle after it is accepted.
    localparam int unsigned LATENCY      = 1;
    // Generous stop for the whole run; the slowest legal run is far shorter.
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    // Bound on how long a drain may wait for missing results.
    localparam int unsigned DRAIN_LIMIT  = 2000;
    localparam int unsigned PHASE_ITEMS  = 150;
    // Requests in the closing fast-clock stretch, a few minute rollovers.
    localparam int unsigned FAST_ITEMS   = 150;

    // Register index beyond the map; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    // Lit segments a..g for digits 0..9, active high.
    localparam logic [SEG_W-1:0] SEG_LIT [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    typedef enum logic {
        STEP_REQUEST,
        STEP_WRITE
    } t_step_kind;

    typedef enum logic [2:0] {
        MIX_MIN_PERIODS,
        MIX_ZERO_PERIODS,
        MIX_DEFAULTS,
        MIX_RANDOM,
        MIX_FAST_CLOCK
    } t_mix;

    // One row of the directed script: either a tick request or a register
    // write. A row may carry a typed-in display that replaces the prediction.
    typedef struct packed {
        t_step_kind           kind;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0] reg_data;
        logic                 tick;
        logic                 typed;
        t_result              want;
    } t_script_row;

    // Display right after reset: all latches clear, clock at 15:08:50.
    localparam t_result RESET_DISPLAY = '{
        digit_enable_n: 4'h0, segments_n: 7'h00, dot_led: 1'b0, red_led: 1'b0,
        matrix_rows: 8'h00, matrix_columns: 8'h00,
        clock_hours: 5'd15, clock_minutes: 6'd8, clock_seconds: 6'd50
    };

    localparam int unsigned SCRIPT_LEN = 25;

    // The first two requests come before any countdown can expire, so the
    // display still shows the reset state. The writes then cover the unmapped
    // index, glyph words of all ones and all zeros, a zero row period (the row
    // job fires on every tick once it reloads), and a period written with all
    // data bits set, of which only the low ten bits count.
    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        '{STEP_REQUEST, CFG_DIGIT_SCAN, 32'h0, 1'b0, 1'b1, RESET_DISPLAY},
        '{STEP_REQUEST, CFG_DIGIT_SCAN, 32'h0, 1'b1, 1'b1, RESET_DISPLAY},
        '{STEP_WRITE,   CFG_UNMAPPED,   32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{STEP_WRITE,   CFG_GLYPH_LOW,  32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{STEP_WRITE,   CFG_GLYPH_HIGH, 32'h0000_0000, 1'b0, 1'b0, '0},
        '{STEP_WRITE,   CFG_ROW_SCAN,   32'h0000_0000, 1'b0, 1'b0, '0},
        '{STEP_WRITE,   CFG_DIGIT_SCAN, 32'h0000_0001, 1'b0, 1'b0, '0},
        '{STEP_WRITE,   CFG_DOT_BLINK,  32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{STEP_WRITE,   CFG_RED_BLINK,  32'h0000_0000, 1'b0, 1'b0, '0},
        '{STEP_WRITE,   CFG_SECOND,     32'h0000_0001, 1'b0, 1'b0, '0},
        '{STEP_REQUEST, CFG_DIGIT_SCAN, 32'h0, 1'b1, 1'b0, '0},
        '{STEP_REQUEST, CFG_DIGIT_SCAN, 32'h0, 1'b1, 1'b0, '0},
        '{STEP_REQUEST, CFG_DIGIT_SCAN, 32'h0, 1'b1, 1'b0, '0},
        '{STEP_REQUEST, CFG_DIGIT_SCAN, 32'h0, 1'b1, 1'b0, '0},
        '{STEP_REQUEST, CFG_DIGIT_SCAN, 32'h0, 1'b1, 1'b0, '0},
        '{STEP_REQUEST, CFG_DIGIT_SCAN, 32'h0, 1'b1, 1'b0, '0},
        '{STEP_REQUEST, CFG_DIGIT_SCAN, 32'h0, 1'b1, 1'b0, '0},
        '{STEP_REQUEST, CFG_DIGIT_SCAN, 32'h0, 1'b1, 1'b0, '0},
        '{STEP_REQUEST, CFG_DIGIT_SCAN, 32'h0, 1'b1, 1'b0, '0},
        '{STEP_REQUEST, CFG_DIGIT_SCAN, 32'h0, 1'b1, 1'b0, '0},
        '{STEP_REQUEST, CFG_DIGIT_SCAN, 32'h0, 1'b1, 1'b0, '0},
        '{STEP_REQUEST, CFG_DIGIT_SCAN, 32'h0, 1'b1, 1'b0, '0},
        '{STEP_REQUEST, CFG_DIGIT_SCAN, 32'h0, 1'b0, 1'b0, '0},
        '{STEP_REQUEST, CFG_DIGIT_SCAN, 32'h0, 1'b1, 1'b0, '0},
        '{STEP_WRITE,   CFG_SECOND,     32'h0000_0000, 1'b0, 1'b0, '0}
    };

    // Ports of the block.
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_tick;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [ENABLE_W-1:0]   o_digit_enable_n;
    logic [SEG_W-1:0]      o_segments_n;
    logic                  o_dot_led;
    logic                  o_red_led;
    logic [ROW_W-1:0]      o_matrix_rows;
    logic [COL_W-1:0]      o_matrix_columns;
    logic [HOUR_W-1:0]     o_clock_hours;
    logic [MIN_W-1:0]      o_clock_minutes;
    logic [SEC_W-1:0]      o_clock_seconds;

    // A typed-in display rides along with its request like a payload field,
    // so it is driven and sampled on the same edges as i_tick.
    logic                  typed_check;
    t_result               typed_display;

    // Displays still owed by the block, oldest first.
    t_result               pending_displays [$];
    t_result               predicted;
    int unsigned           fail_count;
    int unsigned           cycle_count;
    logic                  idle_on;
    int unsigned           stall_left;

    // Predictor state: registers, countdowns, clock, scan positions, latches.
    logic [PERIOD_W-1:0]   period    [NUM_JOBS];
    logic [PERIOD_W-1:0]   countdown [NUM_JOBS];
    logic [GLYPH_W-1:0]    glyph_lo;
    logic [GLYPH_W-1:0]    glyph_hi;
    logic [HOUR_W-1:0]     hours;
    logic [MIN_W-1:0]      minutes;
    logic [SEC_W-1:0]      seconds;
    logic [1:0]            digit_pos;
    logic [ROW_SEL_W-1:0]  row_pos;
    logic [SCROLL_W-1:0]   scroll;
    logic                  dot;
    logic                  red;
    logic [ENABLE_W-1:0]   enable_l;
    logic [SEG_W-1:0]      segment_l;
    logic [ROW_W-1:0]      row_l;
    logic [COL_W-1:0]      column_l;

    tick_driven_clock_and_led_scanner_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_tick           (i_tick),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_digit_enable_n (o_digit_enable_n),
        .o_segments_n     (o_segments_n),
        .o_dot_led        (o_dot_led),
        .o_red_led        (o_red_led),
        .o_matrix_rows    (o_matrix_rows),
        .o_matrix_columns (o_matrix_columns),
        .o_clock_hours    (o_clock_hours),
        .o_clock_minutes  (o_clock_minutes),
        .o_clock_seconds  (o_clock_seconds)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    task automatic clear_display_model();
        for (int j = 0; j < NUM_JOBS; j++) begin
            period[j]    = PERIOD_RST[j];
            countdown[j] = PERIOD_RST[j];
        end
        glyph_lo      = GLYPH_LOW_RST;
        glyph_hi      = GLYPH_HIGH_RST;
        hours         = HOUR_RST;
        minutes       = MIN_RST;
        seconds       = SEC_RST;
        digit_pos     = '0;
        row_pos       = '0;
        scroll        = '0;
        dot           = 1'b0;
        red           = 1'b0;
        enable_l      = '0;
        segment_l     = '0;
        row_l         = '0;
        column_l      = '0;
    endtask

    // A countdown at one or zero expires and reloads; otherwise it counts down.
    function automatic logic job_due(input int j);
        if (countdown[j] <= 10'd1) begin
            countdown[j] = period[j];
            return 1'b1;
        end
        countdown[j] = countdown[j] - 10'd1;
        return 1'b0;
    endfunction

    // Display after one request. Jobs run in the order scan, dot, red,
    // second, row, so the digit scan shows the clock before this tick's
    // second update.
    function automatic t_result advance_display(input logic tick);
        t_result     r;
        int unsigned shown;
        int unsigned rp;
        int unsigned g;
        logic [7:0]  line;
        logic [7:0]  cols;
        if (tick) begin
            if (job_due(JOB_SCAN)) begin
                case (t_digit_pos'(digit_pos))
                    DIG_HOUR_TENS:  shown = hours / 10;
                    DIG_HOUR_UNITS: shown = hours % 10;
                    DIG_MIN_TENS:   shown = minutes / 10;
                    default:        shown = minutes % 10;
                endcase
                enable_l  = ~(4'b0001 << digit_pos);
                segment_l = ~((shown < 10) ? SEG_LIT[shown] : SEG_G_ONLY);
                // Four digits fill the two-bit select, so it wraps by itself.
                digit_pos = digit_pos + 2'd1;
            end
            if (job_due(JOB_DOT)) begin
                dot = ~dot;
            end
            if (job_due(JOB_RED)) begin
                red = ~red;
            end
            if (job_due(JOB_SECOND)) begin
                if (seconds == 6'd59) begin
                    seconds = '0;
                    if (minutes == 6'd59) begin
                        minutes = '0;
                        if (hours == 5'd23) begin
                            hours = '0;
                        end else begin
                            hours = hours + 5'd1;
                        end
                    end else begin
                        minutes = minutes + 6'd1;
                    end
                end else begin
                    seconds = seconds + 6'd1;
                end
            end
            if (job_due(JOB_ROW)) begin
                rp   = row_pos;
                line = (rp < 4) ? glyph_lo[rp*8 +: 8] : glyph_hi[(rp-4)*8 +: 8];
                // Column c shows glyph column (c + scroll) mod 9, and glyph
                // column 8 is the blank gap between repeats.
                cols = '0;
                for (int c = 0; c < 8; c++) begin
                    g = (c + scroll) % 9;
                    if (g < 8 && line[7-g]) begin
                        cols[c] = 1'b1;
                    end
                end
                row_l    = 8'b1 << rp;
                column_l = cols;
                if (row_pos == 3'd7) begin
                    row_pos = '0;
                    scroll  = (scroll == 4'd8) ? 4'd0 : scroll + 4'd1;
                end else begin
                    row_pos = row_pos + 3'd1;
                end
            end
        end
        r.digit_enable_n = enable_l;
        r.segments_n     = segment_l;
        r.dot_led        = dot;
        r.red_led        = red;
        r.matrix_rows    = row_l;
        r.matrix_columns = column_l;
        r.clock_hours    = hours;
        r.clock_minutes  = minutes;
        r.clock_seconds  = seconds;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // Everything is sampled at the rising edge, before any of this edge's
    // updates land, so the order of processes within the step does not matter.
    // A request accepted at this edge feeds the predictor; a result taken at
    // this edge is checked against the oldest owed display.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_displays.size() == 0) begin
                    fail_count++;
                    $error("result arrived with no request outstanding");
                end else begin
                    predicted = pending_displays.pop_front();
                    compare_field("digit_enable_n", predicted.digit_enable_n,
                                  o_digit_enable_n);
                    compare_field("segments_n", predicted.segments_n, o_segments_n);
                    compare_field("dot_led", predicted.dot_led, o_dot_led);
                    compare_field("red_led", predicted.red_led, o_red_led);
                    compare_field("matrix_rows", predicted.matrix_rows, o_matrix_rows);
                    compare_field("matrix_columns", predicted.matrix_columns,
                                  o_matrix_columns);
                    compare_field("clock_hours", predicted.clock_hours, o_clock_hours);
                    compare_field("clock_minutes", predicted.clock_minutes,
                                  o_clock_minutes);
                    compare_field("clock_seconds", predicted.clock_seconds,
                                  o_clock_seconds);
                end
            end
            if (i_in_valid && o_in_ready) begin
                predicted = advance_display(i_tick);
                pending_displays.push_back(typed_check ? typed_display : predicted);
            end
        end
    end

    // Receiver: stalls come in random bursts while idling is on.
    // A burst already running finishes after idling is switched off.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 13);
        end
        i_out_ready <= (stall_left == 0);
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Offers one tick request and returns at the edge that accepts it, with
    // valid still high so the next request can follow back to back. The
    // sender may first drop valid for a random burst.
    task automatic send_request(input logic tick, input logic typed, input t_result want);
        i_cfg_we <= 1'b0;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_tick        <= tick;
        typed_check   <= typed;
        typed_display <= want;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
    endtask

    // Stops offering requests and waits until every owed display has come
    // back, then lets the pipeline settle.
    task automatic drain_results();
        int unsigned waited;
        i_in_valid <= 1'b0;
        i_cfg_we   <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (pending_displays.size() != 0 && waited < DRAIN_LIMIT);
        if (pending_displays.size() != 0) begin
            fail_count++;
            $error("%0d results never arrived", pending_displays.size());
            pending_displays.delete();
        end
        repeat (LATENCY + 1) @(posedge i_clk);
    endtask

    // Register writes only happen with the block idle. Period registers keep
    // the low ten bits; a new period is picked up at that job's next reload.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (index < NUM_JOBS) begin
            period[index] = data[PERIOD_W-1:0];
        end else if (index == CFG_GLYPH_LOW) begin
            glyph_lo = data;
        end else if (index == CFG_GLYPH_HIGH) begin
            glyph_hi = data;
        end
    endtask

    // Mostly short periods so the jobs fire often, with zero, one and the
    // largest period mixed in. The unused upper data bits are randomized.
    function automatic logic [CFG_DATA_W-1:0] random_period();
        logic [PERIOD_W-1:0] p;
        case ($urandom_range(0, 5))
            0:       p = 10'd0;
            1:       p = 10'd1;
            2, 3:    p = 10'($urandom_range(2, 12));
            4:       p = 10'($urandom_range(13, 1023));
            default: p = 10'd1023;
        endcase
        return ($urandom() & 32'hFFFF_FC00) | 32'(p);
    endfunction

    // Writes every register for the next stretch of traffic.
    task automatic configure(input t_mix mix);
        logic [CFG_DATA_W-1:0] job_word [NUM_JOBS];
        logic [CFG_DATA_W-1:0] low_word;
        logic [CFG_DATA_W-1:0] high_word;
        for (int j = 0; j < NUM_JOBS; j++) begin
            case (mix)
                MIX_MIN_PERIODS:  job_word[j] = 32'd1;
                MIX_ZERO_PERIODS: job_word[j] = $urandom() & 32'hFFFF_FC00;
                MIX_DEFAULTS:     job_word[j] = 32'(PERIOD_RST[j]);
                default:          job_word[j] = random_period();
            endcase
        end
        case (mix)
            MIX_MIN_PERIODS: begin
                low_word  = 32'hFFFF_FFFF;
                high_word = 32'hFFFF_FFFF;
            end
            MIX_ZERO_PERIODS: begin
                low_word  = 32'h0000_0000;
                high_word = 32'h0000_0000;
            end
            MIX_DEFAULTS: begin
                low_word  = GLYPH_LOW_RST;
                high_word = GLYPH_HIGH_RST;
            end
            default: begin
                low_word  = $urandom();
                high_word = $urandom();
            end
        endcase
        // Fast clock: one clock second per tick through a zero period, the
        // slowest digit scan and dot blink, and a quick red blink and row scan.
        if (mix == MIX_FAST_CLOCK) begin
            job_word[JOB_SCAN]   = 32'd1023;
            job_word[JOB_DOT]    = 32'd1023;
            job_word[JOB_RED]    = 32'd1;
            job_word[JOB_SECOND] = 32'd0;
            job_word[JOB_ROW]    = 32'd2;
        end
        write_reg(CFG_DIGIT_SCAN, job_word[JOB_SCAN]);
        write_reg(CFG_DOT_BLINK, job_word[JOB_DOT]);
        write_reg(CFG_RED_BLINK, job_word[JOB_RED]);
        write_reg(CFG_SECOND, job_word[JOB_SECOND]);
        write_reg(CFG_ROW_SCAN, job_word[JOB_ROW]);
        write_reg(CFG_GLYPH_LOW, low_word);
        write_reg(CFG_GLYPH_HIGH, high_word);
        if (mix == MIX_RANDOM) begin
            write_reg(CFG_UNMAPPED, $urandom());
        end
    endtask

    task automatic run_phase(input t_mix mix, input logic idling);
        idle_on = idling;
        configure(mix);
        // Mostly ticks; a request without a tick must leave everything alone.
        repeat (PHASE_ITEMS) begin
            send_request($urandom_range(0, 4) != 0, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial begin
        // Every input is known from time zero; reset is held before the directed script.
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_tick        = 1'b0;
        i_out_ready   = 1'b0;
        typed_check   = 1'b0;
        typed_display = '0;
        idle_on       = 1'b1;
        stall_left    = 0;
        fail_count    = 0;
        clear_display_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed script: reset display, register extremes, zero periods.
        for (int i = 0; i < SCRIPT_LEN; i++) begin
            if (SCRIPT[i].kind == STEP_WRITE) begin
                write_reg(SCRIPT[i].reg_index, SCRIPT[i].reg_data);
            end else begin
                send_request(SCRIPT[i].tick, SCRIPT[i].typed, SCRIPT[i].want);
            end
        end

        // Random traffic under a series of register settings. Idling is
        // switched off for some phases so back-to-back requests are covered.
        run_phase(MIX_MIN_PERIODS, 1'b1);
        run_phase(MIX_ZERO_PERIODS, 1'b1);
        run_phase(MIX_DEFAULTS, 1'b0);
        for (int p = 0; p < 6; p++) begin
            run_phase(MIX_RANDOM, (p % 3) != 2);
        end

        // Last part, with no idling on either side: run the clock one second
        // per tick so the seconds roll over into the minutes a few times.
        idle_on = 1'b0;
        configure(MIX_FAST_CLOCK);
        repeat (FAST_ITEMS) begin
            send_request($urandom_range(0, 49) != 0, 1'b0, '0);
        end

        drain_results();
        repeat (LATENCY + 4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

>>> tick_driven_clock_and_led_scanner_top.f
design/tdcls_pkg.sv
design/tdcls_cfg_regs.sv
design/tdcls_job_timers.sv
design/tdcls_scan_core.sv
design/tick_driven_clock_and_led_scanner_top.sv
tb/testbench.sv
